// File: hw/rtl/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int ALU_STEPS   = DATA_W;
  localparam int STEP_W      = $clog2(ALU_STEPS);

  localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_DEPTH = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_FIX
  } alu_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ALU,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  answer;
    logic                      finished;
  } res_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// File: hw/rtl/rpn_if.sv
`timescale 1ns / 1ps

interface rpn_tok_if;
  logic                                valid;
  logic                                ready;
  logic [rpn_pkg::FUNC_W-1:0]          func;
  logic                                is_end;
  logic signed [rpn_pkg::DATA_W-1:0]   number;

  modport source (output valid, func, is_end, number, input ready);
  modport sink   (input valid, func, is_end, number, output ready);
endinterface

interface rpn_res_if;
  logic                                valid;
  logic                                ready;
  logic [rpn_pkg::STATUS_W-1:0]        status;
  logic signed [rpn_pkg::DATA_W-1:0]   answer;
  logic                                finished;

  modport source (output valid, status, answer, finished, input ready);
  modport sink   (input valid, status, answer, finished, output ready);
endinterface

// File: hw/rtl/rpn_stack_evaluator_top.sv
`timescale 1ns / 1ps
// Push, end, unknown tokens and errors bypass the arithmetic unit; add and
// subtract make one pass through it. Multiply and divide iterate 32 times on
// the shared adder, divide with a final negation step when the signs differ.
// A new token is taken only once the last result has moved to the output,
// where it may wait while the next token runs. Synchronous reset empties the
// stack and drops any pending result; stack memory contents are not cleared.

module rpn_stack_evaluator_top (
  input  logic             clk,
  input  logic             rst,
  rpn_tok_if.sink          tok,
  rpn_res_if.source        res
);

  rpn_pkg::ctrl_state_t state;
  rpn_pkg::ctrl_state_t state_next;

  logic [rpn_pkg::CNT_W-1:0]    depth;
  logic [rpn_pkg::CNT_W-1:0]    depth_next;
  logic [rpn_pkg::FUNC_W-1:0]   tok_func;
  logic                         tok_end;
  logic [rpn_pkg::DATA_W-1:0]   tok_number;
  rpn_pkg::res_t                res_q;
  rpn_pkg::res_t                res_next;
  rpn_pkg::res_t                out_q;
  logic                         out_valid;
  logic                         out_free;

  logic [rpn_pkg::DATA_W-1:0]   rd_top;
  logic [rpn_pkg::DATA_W-1:0]   rd_below;
  logic [rpn_pkg::CNT_W-1:0]    depth_m1;
  logic [rpn_pkg::CNT_W-1:0]    depth_m2;
  rpn_pkg::mem_wr_t             mem_wr;
  rpn_pkg::alu_req_t            alu_req;
  rpn_pkg::alu_rsp_t            alu_rsp;

  logic is_op;
  logic few;
  logic full;
  logic div_zero;

  assign depth_m1 = depth - rpn_pkg::CNT_W'(1);
  assign depth_m2 = depth - rpn_pkg::CNT_W'(2);
  assign is_op    = (tok_func >= rpn_pkg::FN_ADD) && (tok_func <= rpn_pkg::FN_DIV);
  assign few      = (depth < rpn_pkg::CNT_W'(2));
  assign full     = (depth >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
  assign div_zero = (tok_func == rpn_pkg::FN_DIV) && (rd_top == '0);
  assign out_free = !out_valid || res.ready;

  rpn_stack_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .raddr_a (depth_m1[rpn_pkg::PTR_W-1:0]),
    .raddr_b (depth_m2[rpn_pkg::PTR_W-1:0]),
    .rdata_a (rd_top),
    .rdata_b (rd_below)
  );

  rpn_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::S_IDLE: begin
        if (tok.valid) begin
          state_next = rpn_pkg::S_EXEC;
        end
      end
      rpn_pkg::S_EXEC: begin
        state_next = alu_req.start ? rpn_pkg::S_ALU : rpn_pkg::S_DONE;
      end
      rpn_pkg::S_ALU: begin
        if (alu_rsp.done) begin
          state_next = rpn_pkg::S_DONE;
        end
      end
      rpn_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rpn_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    tok.ready     = (state == rpn_pkg::S_IDLE);
    alu_req.start = (state == rpn_pkg::S_EXEC) && !tok_end && is_op && !few && !div_zero;
    alu_req.a     = rd_below;
    alu_req.b     = rd_top;
    unique case (tok_func)
      rpn_pkg::FN_SUB: alu_req.op = rpn_pkg::ALU_SUB;
      rpn_pkg::FN_MUL: alu_req.op = rpn_pkg::ALU_MUL;
      rpn_pkg::FN_DIV: alu_req.op = rpn_pkg::ALU_DIV;
      default:         alu_req.op = rpn_pkg::ALU_ADD;
    endcase

    mem_wr.we   = 1'b0;
    mem_wr.addr = depth[rpn_pkg::PTR_W-1:0];
    mem_wr.data = tok_number;
    if (state == rpn_pkg::S_EXEC && !tok_end && tok_func == rpn_pkg::FN_PUSH && !full) begin
      mem_wr.we = 1'b1;
    end else if (state == rpn_pkg::S_ALU && alu_rsp.done) begin
      mem_wr.we   = 1'b1;
      mem_wr.addr = depth_m2[rpn_pkg::PTR_W-1:0];
      mem_wr.data = alu_rsp.result;
    end

    res.valid    = out_valid;
    res.status   = out_q.status;
    res.answer   = out_q.answer;
    res.finished = out_q.finished;
  end

  // An error empties the stack and reports a zero answer.
  always_comb begin
    res_next   = res_q;
    depth_next = depth;
    if (state == rpn_pkg::S_EXEC) begin
      priority if (tok_end) begin
        depth_next = '0;
        if (depth == rpn_pkg::CNT_W'(1)) begin
          res_next = '{rpn_pkg::ST_OK, rd_top, 1'b1};
        end else begin
          res_next = '{rpn_pkg::ST_DEPTH, '0, 1'b1};
        end
      end else if (tok_func == rpn_pkg::FN_PUSH) begin
        if (full) begin
          depth_next = '0;
          res_next   = '{rpn_pkg::ST_FULL, '0, 1'b1};
        end else begin
          depth_next = depth + rpn_pkg::CNT_W'(1);
          res_next   = '{rpn_pkg::ST_OK, tok_number, 1'b0};
        end
      end else if (!is_op) begin
        res_next = '{rpn_pkg::ST_OK, (depth != '0) ? rd_top : '0, 1'b0};
      end else if (few) begin
        depth_next = '0;
        res_next   = '{rpn_pkg::ST_FEW, '0, 1'b1};
      end else if (div_zero) begin
        depth_next = '0;
        res_next   = '{rpn_pkg::ST_DIV0, '0, 1'b1};
      end else begin
        depth_next = depth;
      end
    end else if (state == rpn_pkg::S_ALU && alu_rsp.done) begin
      depth_next = depth_m1;
      res_next   = '{rpn_pkg::ST_OK, alu_rsp.result, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpn_pkg::S_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (state == rpn_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
    if (tok.valid && tok.ready) begin
      tok_func   <= tok.func;
      tok_end    <= tok.is_end;
      tok_number <= tok.number;
    end
    if (state == rpn_pkg::S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack depth above capacity");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != rpn_pkg::ST_OK) |-> (res.answer == '0 && res.finished))
    else $error("error beat carries an answer or is not finished");

  a_alu_owned: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == rpn_pkg::S_ALU))
    else $error("arithmetic unit finished outside its wait state");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.ready) |=> (state == rpn_pkg::S_EXEC))
    else $error("accepted token not executed");
`endif

endmodule

// File: hw/rtl/rpn_stack_mem.sv
`timescale 1ns / 1ps

module rpn_stack_mem (
  input  logic                           clk,
  input  rpn_pkg::mem_wr_t               wr,
  input  logic [rpn_pkg::PTR_W-1:0]      raddr_a,
  input  logic [rpn_pkg::PTR_W-1:0]      raddr_b,
  output logic [rpn_pkg::DATA_W-1:0]     rdata_a,
  output logic [rpn_pkg::DATA_W-1:0]     rdata_b
);

  logic [rpn_pkg::DATA_W-1:0] mem [rpn_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/rpn_alu.sv
`timescale 1ns / 1ps

module rpn_alu (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::alu_req_t  req,
  output rpn_pkg::alu_rsp_t  rsp
);

  rpn_pkg::alu_state_t state;
  rpn_pkg::alu_state_t state_next;

  logic                           done;
  logic [rpn_pkg::DATA_W-1:0]     result;
  logic [rpn_pkg::DATA_W-1:0]     acc;
  logic [rpn_pkg::DATA_W-1:0]     xr;
  logic [rpn_pkg::DATA_W-1:0]     yr;
  logic                           neg;
  logic [rpn_pkg::STEP_W-1:0]     step;
  logic                           last;

  logic [rpn_pkg::DATA_W:0]       add_a;
  logic [rpn_pkg::DATA_W:0]       add_b;
  logic                           add_sub;
  logic [rpn_pkg::DATA_W:0]       sum;
  logic                           fits;

  // The single adder serves every operation: add, subtract, each
  // multiply step, each restoring divide step and the final negation.
  always_comb begin
    unique case (state)
      rpn_pkg::AS_IDLE: begin
        add_a   = {1'b0, req.a};
        add_b   = {1'b0, req.b};
        add_sub = (req.op == rpn_pkg::ALU_SUB);
      end
      rpn_pkg::AS_MUL: begin
        add_a   = {1'b0, acc};
        add_b   = yr[0] ? {1'b0, xr} : '0;
        add_sub = 1'b0;
      end
      rpn_pkg::AS_DIV: begin
        add_a   = {acc, xr[rpn_pkg::DATA_W-1]};
        add_b   = {1'b0, yr};
        add_sub = 1'b1;
      end
      rpn_pkg::AS_FIX: begin
        add_a   = '0;
        add_b   = {1'b0, xr};
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum  = add_a + (add_sub ? ~add_b : add_b) + {{rpn_pkg::DATA_W{1'b0}}, add_sub};
  assign fits = ~sum[rpn_pkg::DATA_W];
  assign last = (step == rpn_pkg::STEP_W'(rpn_pkg::ALU_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::AS_IDLE: begin
        if (req.start && req.op == rpn_pkg::ALU_MUL) begin
          state_next = rpn_pkg::AS_MUL;
        end else if (req.start && req.op == rpn_pkg::ALU_DIV) begin
          state_next = rpn_pkg::AS_DIV;
        end
      end
      rpn_pkg::AS_MUL: begin
        if (last) begin
          state_next = rpn_pkg::AS_IDLE;
        end
      end
      rpn_pkg::AS_DIV: begin
        if (last) begin
          state_next = neg ? rpn_pkg::AS_FIX : rpn_pkg::AS_IDLE;
        end
      end
      rpn_pkg::AS_FIX: begin
        state_next = rpn_pkg::AS_IDLE;
      end
      default: begin
        state_next = rpn_pkg::AS_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done   = done;
    rsp.result = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::AS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        rpn_pkg::AS_IDLE: done <= req.start &&
                                  (req.op == rpn_pkg::ALU_ADD || req.op == rpn_pkg::ALU_SUB);
        rpn_pkg::AS_MUL:  done <= last;
        rpn_pkg::AS_DIV:  done <= last && !neg;
        rpn_pkg::AS_FIX:  done <= 1'b1;
        default:          done <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rpn_pkg::AS_IDLE: begin
        result <= sum[rpn_pkg::DATA_W-1:0];
        acc    <= '0;
        step   <= '0;
        if (req.op == rpn_pkg::ALU_DIV) begin
          xr  <= req.a[rpn_pkg::DATA_W-1] ? (~req.a + rpn_pkg::DATA_W'(1)) : req.a;
          yr  <= req.b[rpn_pkg::DATA_W-1] ? (~req.b + rpn_pkg::DATA_W'(1)) : req.b;
          neg <= req.a[rpn_pkg::DATA_W-1] ^ req.b[rpn_pkg::DATA_W-1];
        end else begin
          xr  <= req.a;
          yr  <= req.b;
          neg <= 1'b0;
        end
      end
      rpn_pkg::AS_MUL: begin
        acc    <= sum[rpn_pkg::DATA_W-1:0];
        xr     <= {xr[rpn_pkg::DATA_W-2:0], 1'b0};
        yr     <= {1'b0, yr[rpn_pkg::DATA_W-1:1]};
        step   <= step + rpn_pkg::STEP_W'(1);
        result <= sum[rpn_pkg::DATA_W-1:0];
      end
      rpn_pkg::AS_DIV: begin
        if (fits) begin
          acc <= sum[rpn_pkg::DATA_W-1:0];
        end else begin
          acc <= {acc[rpn_pkg::DATA_W-2:0], xr[rpn_pkg::DATA_W-1]};
        end
        xr     <= {xr[rpn_pkg::DATA_W-2:0], fits};
        step   <= step + rpn_pkg::STEP_W'(1);
        result <= {xr[rpn_pkg::DATA_W-2:0], fits};
      end
      rpn_pkg::AS_FIX: begin
        result <= sum[rpn_pkg::DATA_W-1:0];
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule
